// ===== sv/i2cblm_pkg.sv =====
// Shared types and constants for the I2C bit-level master sequencer.
// No dependencies; used by the top level, the sequencer and the result buffer.
package i2cblm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_STOP_A   = 4'd3,
    PH_STOP_B   = 4'd4,
    PH_TX_SETUP = 4'd5,
    PH_TX_HIGH  = 4'd6,
    PH_TX_LOW   = 4'd7,
    PH_RX_LOW   = 4'd8,
    PH_RX_HIGH  = 4'd9,
    PH_ACK_LOW  = 4'd10,
    PH_ACK_HIGH = 4'd11,
    PH_WA_LOW   = 4'd12,
    PH_WA_HIGH  = 4'd13,
    PH_WA_POLL  = 4'd14
  } phase_t;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_SEND  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_WAIT  = 3'd5;

  localparam logic CFG_TICKS_PER_US = 1'b0;
  localparam logic CFG_ACK_TIMEOUT  = 1'b1;

  localparam logic [15:0] TICKS_PER_US_RST = 16'd50;
  localparam logic [7:0]  ACK_TIMEOUT_RST  = 8'd250;
  localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } res_t;

  function automatic logic [2:0] units_of(input phase_t ph);
    logic [2:0] u;
    case (ph)
      PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B: u = 3'd4;
      PH_RX_HIGH, PH_WA_LOW, PH_WA_HIGH, PH_WA_POLL: u = 3'd1;
      default: u = 3'd2;
    endcase
    return u;
  endfunction

endpackage

// ===== sv/i2c_bit_level_master_top.sv =====
// I2C bit-level master sequencer, top level with configuration registers.
// Depends on i2cblm_pkg, i2cblm_seq and i2cblm_out_buf.
//
// Each request is one tick of the bus timing and yields exactly one result
// with the line levels after that tick. A request is taken every clock cycle
// while in_ready is high; in_ready drops while the skid entry of the result
// buffer is full. The sequencer state advances in a single registered pass,
// and a two-entry result buffer registers each result and lets one more
// request be taken while a result waits on out_ready.
// Commands arriving while an operation runs are ignored; one delay unit is
// ticks_per_microsecond requests. Write configuration only while idle.
module i2c_bit_level_master_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_give_ack,
  input  logic        in_sda_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_level,
  output logic        out_sda_level,
  output logic        out_sda_drive,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_rx_byte,
  output logic        out_ack_failed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]      ticks_per_us_r;
  logic [7:0]       ack_timeout_r;
  logic             step;
  i2cblm_pkg::res_t seq_res;
  i2cblm_pkg::res_t out_res;

  assign cfg_ready = 1'b1;
  assign step      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_us_r <= i2cblm_pkg::TICKS_PER_US_RST;
      ack_timeout_r  <= i2cblm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        i2cblm_pkg::CFG_TICKS_PER_US: ticks_per_us_r <= cfg_data;
        i2cblm_pkg::CFG_ACK_TIMEOUT:  ack_timeout_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  i2cblm_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .operation    (in_operation),
    .tx_byte      (in_tx_byte),
    .give_ack     (in_give_ack),
    .sda_sample   (in_sda_sample),
    .ticks_per_us (ticks_per_us_r),
    .ack_timeout  (ack_timeout_r),
    .res          (seq_res)
  );

  i2cblm_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .push_data  (seq_res),
    .push_ready (in_ready),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_res)
  );

  assign out_scl_level  = out_res.scl_level;
  assign out_sda_level  = out_res.sda_level;
  assign out_sda_drive  = out_res.sda_drive;
  assign out_busy_res   = out_res.busy_res;
  assign out_done_res   = out_res.done_res;
  assign out_rx_byte    = out_res.rx_byte;
  assign out_ack_failed = out_res.ack_failed;

endmodule

// ===== sv/i2cblm_seq.sv =====
// Bus sequencer: phase, delay counters, shift register and line levels.
// Advances one tick per accepted request; depends on i2cblm_pkg.
module i2cblm_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [2:0]           operation,
  input  logic [7:0]           tx_byte,
  input  logic                 give_ack,
  input  logic                 sda_sample,
  input  logic [15:0]          ticks_per_us,
  input  logic [7:0]           ack_timeout,
  output i2cblm_pkg::res_t     res
);

  i2cblm_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  bit_index_r, bit_index_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] delay_ticks_r, delay_ticks_nxt;
  logic [2:0]  delay_units_r, delay_units_nxt;
  logic [8:0]  poll_r, poll_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        drv_r, drv_nxt;
  logic        ack_choice_r, ack_choice_nxt;
  logic        fail_r, fail_nxt;
  logic [7:0]  rx_hold_r, rx_hold_nxt;
  logic        enter_s, fin_s;
  logic [15:0] unit_ticks;
  logic [15:0] dt;
  logic [2:0]  du;
  logic [3:0]  bi;

  assign unit_ticks = (ticks_per_us == 16'd0) ? 16'd1 : ticks_per_us;

  // next state
  always_comb begin
    phase_nxt       = phase_r;
    bit_index_nxt   = bit_index_r;
    shift_nxt       = shift_r;
    delay_ticks_nxt = delay_ticks_r;
    delay_units_nxt = delay_units_r;
    poll_nxt        = poll_r;
    ack_choice_nxt  = ack_choice_r;
    fail_nxt        = fail_r;
    rx_hold_nxt     = rx_hold_r;
    enter_s         = 1'b0;
    fin_s           = 1'b0;
    dt              = delay_ticks_r - 16'd1;
    du              = delay_units_r - 3'd1;
    bi              = bit_index_r + 4'd1;
    if (phase_r == i2cblm_pkg::PH_IDLE) begin
      case (operation)
        i2cblm_pkg::OP_START: begin
          phase_nxt = i2cblm_pkg::PH_START_A;
          enter_s   = 1'b1;
        end
        i2cblm_pkg::OP_STOP: begin
          phase_nxt = i2cblm_pkg::PH_STOP_A;
          enter_s   = 1'b1;
        end
        i2cblm_pkg::OP_SEND: begin
          shift_nxt     = tx_byte;
          bit_index_nxt = 4'd0;
          phase_nxt     = i2cblm_pkg::PH_TX_SETUP;
          enter_s       = 1'b1;
        end
        i2cblm_pkg::OP_READ: begin
          ack_choice_nxt = give_ack;
          shift_nxt      = 8'd0;
          bit_index_nxt  = 4'd0;
          phase_nxt      = i2cblm_pkg::PH_RX_LOW;
          enter_s        = 1'b1;
        end
        i2cblm_pkg::OP_WAIT: begin
          fail_nxt  = 1'b0;
          poll_nxt  = 9'd0;
          phase_nxt = i2cblm_pkg::PH_WA_LOW;
          enter_s   = 1'b1;
        end
        default: ;
      endcase
    end else begin
      delay_ticks_nxt = dt;
      if (dt == 16'd0) begin
        delay_units_nxt = du;
        if (du != 3'd0) begin
          delay_ticks_nxt = unit_ticks;
        end else begin
          case (phase_r)
            i2cblm_pkg::PH_START_A: begin
              phase_nxt = i2cblm_pkg::PH_START_B;
              enter_s   = 1'b1;
            end
            i2cblm_pkg::PH_STOP_A: begin
              phase_nxt = i2cblm_pkg::PH_STOP_B;
              enter_s   = 1'b1;
            end
            i2cblm_pkg::PH_START_B, i2cblm_pkg::PH_STOP_B, i2cblm_pkg::PH_ACK_HIGH: begin
              fin_s = 1'b1;
            end
            i2cblm_pkg::PH_TX_SETUP: begin
              phase_nxt = i2cblm_pkg::PH_TX_HIGH;
              enter_s   = 1'b1;
            end
            i2cblm_pkg::PH_TX_HIGH: begin
              phase_nxt = i2cblm_pkg::PH_TX_LOW;
              enter_s   = 1'b1;
            end
            i2cblm_pkg::PH_TX_LOW: begin
              bit_index_nxt = bi;
              if (bi >= i2cblm_pkg::BITS_PER_BYTE) begin
                fin_s = 1'b1;
              end else begin
                shift_nxt = {shift_r[6:0], 1'b0};
                phase_nxt = i2cblm_pkg::PH_TX_SETUP;
                enter_s   = 1'b1;
              end
            end
            i2cblm_pkg::PH_RX_LOW: begin
              shift_nxt = {shift_r[6:0], sda_sample};
              phase_nxt = i2cblm_pkg::PH_RX_HIGH;
              enter_s   = 1'b1;
            end
            i2cblm_pkg::PH_RX_HIGH: begin
              bit_index_nxt = bi;
              enter_s       = 1'b1;
              if (bi < i2cblm_pkg::BITS_PER_BYTE) begin
                phase_nxt = i2cblm_pkg::PH_RX_LOW;
              end else begin
                rx_hold_nxt = shift_r;
                phase_nxt   = i2cblm_pkg::PH_ACK_LOW;
              end
            end
            i2cblm_pkg::PH_ACK_LOW: begin
              phase_nxt = i2cblm_pkg::PH_ACK_HIGH;
              enter_s   = 1'b1;
            end
            i2cblm_pkg::PH_WA_LOW: begin
              phase_nxt = i2cblm_pkg::PH_WA_HIGH;
              enter_s   = 1'b1;
            end
            i2cblm_pkg::PH_WA_HIGH, i2cblm_pkg::PH_WA_POLL: begin
              if (phase_r == i2cblm_pkg::PH_WA_POLL && poll_r > {1'b0, ack_timeout}) begin
                fail_nxt  = 1'b1;
                phase_nxt = i2cblm_pkg::PH_STOP_A;
                enter_s   = 1'b1;
              end else if (!sda_sample) begin
                fin_s = 1'b1;
              end else begin
                poll_nxt  = poll_r + 9'd1;
                phase_nxt = i2cblm_pkg::PH_WA_POLL;
                enter_s   = 1'b1;
              end
            end
            default: phase_nxt = i2cblm_pkg::PH_IDLE;
          endcase
        end
      end
    end
    if (fin_s) begin
      phase_nxt = i2cblm_pkg::PH_IDLE;
    end
    if (enter_s) begin
      delay_ticks_nxt = unit_ticks;
      delay_units_nxt = i2cblm_pkg::units_of(phase_nxt);
    end
  end

  // line levels
  always_comb begin
    scl_nxt = scl_r;
    sda_nxt = sda_r;
    drv_nxt = drv_r;
    if (enter_s) begin
      case (phase_nxt)
        i2cblm_pkg::PH_START_A: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b1;
        end
        i2cblm_pkg::PH_START_B: begin
          scl_nxt = 1'b1; sda_nxt = 1'b0; drv_nxt = 1'b1;
        end
        i2cblm_pkg::PH_STOP_A: begin
          scl_nxt = 1'b0; sda_nxt = 1'b0; drv_nxt = 1'b1;
        end
        i2cblm_pkg::PH_STOP_B: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b1;
        end
        i2cblm_pkg::PH_TX_SETUP: begin
          scl_nxt = 1'b0; sda_nxt = shift_nxt[7]; drv_nxt = 1'b1;
        end
        i2cblm_pkg::PH_TX_HIGH, i2cblm_pkg::PH_ACK_HIGH: begin
          scl_nxt = 1'b1; drv_nxt = 1'b1;
        end
        i2cblm_pkg::PH_TX_LOW: begin
          scl_nxt = 1'b0; drv_nxt = 1'b1;
        end
        i2cblm_pkg::PH_RX_LOW: begin
          scl_nxt = 1'b0; drv_nxt = 1'b0;
        end
        i2cblm_pkg::PH_RX_HIGH: begin
          scl_nxt = 1'b1; drv_nxt = 1'b0;
        end
        i2cblm_pkg::PH_ACK_LOW: begin
          scl_nxt = 1'b0; sda_nxt = !ack_choice_nxt; drv_nxt = 1'b1;
        end
        i2cblm_pkg::PH_WA_LOW: begin
          scl_nxt = 1'b0; sda_nxt = 1'b1; drv_nxt = 1'b0;
        end
        i2cblm_pkg::PH_WA_HIGH: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b0;
        end
        default: ;
      endcase
    end else if (fin_s && phase_r != i2cblm_pkg::PH_STOP_B
                 && phase_r != i2cblm_pkg::PH_TX_LOW) begin
      scl_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= i2cblm_pkg::PH_IDLE;
      bit_index_r   <= 4'd0;
      shift_r       <= 8'd0;
      delay_ticks_r <= 16'd0;
      delay_units_r <= 3'd0;
      poll_r        <= 9'd0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      drv_r         <= 1'b0;
      ack_choice_r  <= 1'b0;
      fail_r        <= 1'b0;
      rx_hold_r     <= 8'd0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      bit_index_r   <= bit_index_nxt;
      shift_r       <= shift_nxt;
      delay_ticks_r <= delay_ticks_nxt;
      delay_units_r <= delay_units_nxt;
      poll_r        <= poll_nxt;
      scl_r         <= scl_nxt;
      sda_r         <= sda_nxt;
      drv_r         <= drv_nxt;
      ack_choice_r  <= ack_choice_nxt;
      fail_r        <= fail_nxt;
      rx_hold_r     <= rx_hold_nxt;
    end
  end

  always_comb begin
    res.scl_level  = scl_nxt;
    res.sda_level  = sda_nxt;
    res.sda_drive  = drv_nxt;
    res.busy_res   = phase_nxt != i2cblm_pkg::PH_IDLE;
    res.done_res   = fin_s;
    res.rx_byte    = rx_hold_nxt;
    res.ack_failed = fail_nxt;
  end

endmodule

// ===== sv/i2cblm_out_buf.sv =====
// Result register with a skid entry; the request side waits on out_ready only when the skid entry is full.
// Depends on i2cblm_pkg for the result struct.
module i2cblm_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  i2cblm_pkg::res_t push_data,
  output logic             push_ready,
  output logic             pop_valid,
  input  logic             pop_ready,
  output i2cblm_pkg::res_t pop_data
);

  logic             main_v_r, main_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  i2cblm_pkg::res_t main_d_r, main_d_nxt;
  i2cblm_pkg::res_t skid_d_r, skid_d_nxt;

  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!main_v_r || pop_ready) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = push;
        main_d_nxt = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign push_ready = !skid_v_r;
  assign pop_valid  = main_v_r;
  assign pop_data   = main_d_r;

endmodule

// ===== sv/i2cblm_checker.sv =====
// Port-level checks for the I2C bit-level master sequencer.
// Bound to i2c_bit_level_master_top; depends on nothing else.
module i2cblm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_scl_level,
  input logic       out_sda_level,
  input logic       out_sda_drive,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic [7:0] out_rx_byte,
  input logic       out_ack_failed
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rx_byte)
      && $stable(out_scl_level) && $stable(out_sda_level))
    else $error("result changed while stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while still busy");

  a_fail_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ack_failed && !out_busy_res |-> out_sda_drive)
    else $error("idle after ack failure with sda released");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind i2c_bit_level_master_top i2cblm_checker u_i2cblm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_scl_level  (out_scl_level),
  .out_sda_level  (out_sda_level),
  .out_sda_drive  (out_sda_drive),
  .out_busy_res   (out_busy_res),
  .out_done_res   (out_done_res),
  .out_rx_byte    (out_rx_byte),
  .out_ack_failed (out_ack_failed)
);
